[hdl/pcft_pkg.sv]
// Package for the prefix completion frequency table.
// Holds the table sizes, the entry layout and the status codes.
// No dependencies.
package pcft_pkg;

	localparam int TABLE_ENTRIES = 256;
	localparam int COUNT_BITS    = 32;
	localparam int MAX_CHARS     = 16;
	localparam int WORD_BITS     = 8 * MAX_CHARS;
	localparam int LEN_BITS      = 5;
	localparam int IDX_BITS      = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int FILL_BITS     = IDX_BITS + 1;
	localparam int ENTRY_BITS    = WORD_BITS + LEN_BITS + COUNT_BITS;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	localparam logic [2:0] ST_FOUND   = 3'd0;
	localparam logic [2:0] ST_NOMATCH = 3'd1;
	localparam logic [2:0] ST_ADDED   = 3'd2;
	localparam logic [2:0] ST_AGAIN   = 3'd3;
	localparam logic [2:0] ST_FULL    = 3'd4;

	localparam logic FUNC_UPDATE = 1'b0;
	localparam logic FUNC_SEARCH = 1'b1;

	typedef struct packed {
		logic [WORD_BITS-1:0]  word;
		logic [LEN_BITS-1:0]   len;
		logic [COUNT_BITS-1:0] count;
	} entry_t;

endpackage

[hdl/pcft_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module pcft_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hdl/prefix_completion_frequency_table_unit.sv]
// Top level of the prefix completion frequency table.
// Depends on pcft_pkg and pcft_ram.
//
// One transaction is taken while busy is low; its result appears for one cycle
// with done high, and the receiver cannot stall it. Every transaction scans the
// stored words (at most TABLE_ENTRIES) one per cycle through the entry RAM read
// port. Entries fill from index zero and are never removed, so a fill count
// marks valid entries and no clearing pass follows reset.
module prefix_completion_frequency_table_unit
	import pcft_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic                 func,
	input  logic [63:0]          text_low,
	input  logic [63:0]          text_high,
	input  logic [LEN_BITS-1:0]  text_len,
	output logic                 done,
	output logic [2:0]           status,
	output logic [63:0]          rest_low,
	output logic [63:0]          rest_high,
	output logic [LEN_BITS-1:0]  rest_len
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;

	logic [1:0]            state_q;
	logic [FILL_BITS-1:0]  fill_q;
	logic [FILL_BITS-1:0]  scan_q;
	logic                  rd_vld_q;
	logic [IDX_BITS-1:0]   rd_idx_q;
	logic                  func_q;
	logic [WORD_BITS-1:0]  text_q;
	logic [LEN_BITS-1:0]   len_q;
	logic [WORD_BITS-1:0]  mask_q;
	logic                  hit_q;
	logic [IDX_BITS-1:0]   hit_idx_q;
	logic [COUNT_BITS-1:0] hit_cnt_q;
	logic                  best_vld_q;
	entry_t                best_q;
	logic                  done_q;
	logic [2:0]            status_q;
	logic [63:0]           rest_low_q;
	logic [63:0]           rest_high_q;
	logic [LEN_BITS-1:0]   rest_len_q;

	entry_t                rd_entry;
	entry_t                wr_entry;
	logic                  we;
	logic [IDX_BITS-1:0]   waddr;
	logic [LEN_BITS-1:0]   in_len;
	logic [WORD_BITS-1:0]  in_mask;
	logic                  issue;
	logic                  scan_end;
	logic                  word_hit;
	logic                  pref_hit;
	logic                  better;
	logic [WORD_BITS+LEN_BITS-1:0] key_rd;
	logic [WORD_BITS+LEN_BITS-1:0] key_best;
	logic [WORD_BITS-1:0]  suffix;

	// Byte 0 becomes the most significant so that a plain compare is lexicographic.
	function automatic logic [WORD_BITS-1:0] rev_bytes(input logic [WORD_BITS-1:0] w);
		logic [WORD_BITS-1:0] r;
		for (int i = 0; i < MAX_CHARS; i++) begin
			r[8*i +: 8] = w[8*(MAX_CHARS-1-i) +: 8];
		end
		return r;
	endfunction

	assign in_len = (text_len > LEN_BITS'(MAX_CHARS)) ? LEN_BITS'(MAX_CHARS) : text_len;

	always_comb begin
		for (int i = 0; i < MAX_CHARS; i++) begin
			in_mask[8*i +: 8] = (LEN_BITS'(i) < in_len) ? 8'hFF : 8'h00;
		end
	end

	assign issue    = (state_q == S_SCAN) && (scan_q < fill_q);
	assign scan_end = (state_q == S_SCAN) && !issue && !rd_vld_q;

	pcft_ram #(
		.WIDTH(ENTRY_BITS),
		.DEPTH(TABLE_ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wr_entry),
		.raddr(scan_q[IDX_BITS-1:0]),
		.rdata(rd_entry)
	);

	assign word_hit = (rd_entry.len == len_q) && (rd_entry.word == text_q);
	assign pref_hit = (rd_entry.len >= len_q) && (((rd_entry.word ^ text_q) & mask_q) == '0);
	assign key_rd   = {rev_bytes(rd_entry.word), rd_entry.len};
	assign key_best = {rev_bytes(best_q.word), best_q.len};
	assign better   = !best_vld_q || (rd_entry.count > best_q.count) ||
		((rd_entry.count == best_q.count) && (key_rd < key_best));

	assign suffix = best_q.word >> {len_q, 3'b000};

	// Write back on finish of an update: recount a hit, or store a new word while the table has room.
	always_comb begin
		we             = 1'b0;
		waddr          = hit_idx_q;
		wr_entry.word  = text_q;
		wr_entry.len   = len_q;
		wr_entry.count = (hit_cnt_q == COUNT_MAX) ? hit_cnt_q : hit_cnt_q + 1'b1;
		if (state_q == S_FIN && func_q == FUNC_UPDATE) begin
			if (hit_q) begin
				we = 1'b1;
			end else if (fill_q < FILL_BITS'(TABLE_ENTRIES)) begin
				we             = 1'b1;
				waddr          = fill_q[IDX_BITS-1:0];
				wr_entry.count = COUNT_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			fill_q   <= '0;
			scan_q   <= '0;
			rd_vld_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q   <= 1'b0;
			rd_vld_q <= issue;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_SCAN;
						scan_q  <= '0;
					end
				end
				S_SCAN: begin
					if (issue) begin
						scan_q <= scan_q + 1'b1;
					end
					if (scan_end) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
					if (func_q == FUNC_UPDATE && !hit_q &&
						fill_q < FILL_BITS'(TABLE_ENTRIES)) begin
						fill_q <= fill_q + 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_q <= scan_q[IDX_BITS-1:0];
		if (state_q == S_IDLE && start) begin
			func_q     <= func;
			text_q     <= {text_high, text_low} & in_mask;
			len_q      <= in_len;
			mask_q     <= in_mask;
			hit_q      <= 1'b0;
			best_vld_q <= 1'b0;
		end
		if (state_q == S_SCAN && rd_vld_q) begin
			if (func_q == FUNC_UPDATE) begin
				if (word_hit) begin
					hit_q     <= 1'b1;
					hit_idx_q <= rd_idx_q;
					hit_cnt_q <= rd_entry.count;
				end
			end else if (pref_hit && better) begin
				best_vld_q <= 1'b1;
				best_q     <= rd_entry;
			end
		end
		if (state_q == S_FIN) begin
			rest_low_q  <= '0;
			rest_high_q <= '0;
			rest_len_q  <= '0;
			if (func_q == FUNC_UPDATE) begin
				if (hit_q) begin
					status_q <= ST_AGAIN;
				end else if (fill_q < FILL_BITS'(TABLE_ENTRIES)) begin
					status_q <= ST_ADDED;
				end else begin
					status_q <= ST_FULL;
				end
			end else if (best_vld_q) begin
				status_q    <= ST_FOUND;
				rest_low_q  <= suffix[63:0];
				rest_high_q <= suffix[127:64];
				rest_len_q  <= best_q.len - len_q;
			end else begin
				status_q <= ST_NOMATCH;
			end
		end
	end

	assign busy      = (state_q != S_IDLE);
	assign done      = done_q;
	assign status    = status_q;
	assign rest_low  = rest_low_q;
	assign rest_high = rest_high_q;
	assign rest_len  = rest_len_q;

`ifndef ASSERT_OFF
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_BITS'(TABLE_ENTRIES))
		else $error("fill count beyond table size");
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held longer than one cycle");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("transaction accepted without going busy");
	a_no_read_outside_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_q |-> state_q == S_SCAN)
		else $error("read data returned outside scan");
`endif

endmodule

[test/tb_prefix_completion_frequency_table_unit.sv]
// Self-checking testbench for prefix_completion_frequency_table_unit.
// Depends on pcft_pkg; predicts every transaction's completion or update status
// with its own copy of the word table and checks each done strobe against it.
`timescale 1ns / 100ps

module tb_prefix_completion_frequency_table_unit;
	import pcft_pkg::*;

	localparam int RANDOM_ITEMS = 120;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = TABLE_ENTRIES + 40;

	typedef struct {
		logic [2:0]          status;
		logic [63:0]         rest_low;
		logic [63:0]         rest_high;
		logic [LEN_BITS-1:0] rest_len;
	} completion_t;

	typedef struct {
		logic                f;
		logic [63:0]         lo;
		logic [63:0]         hi;
		logic [LEN_BITS-1:0] len;
		bit                  typed;
		logic [2:0]          st;
	} stim_row_t;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic                func;
	logic [63:0]         text_low;
	logic [63:0]         text_high;
	logic [LEN_BITS-1:0] text_len;
	logic                done;
	logic [2:0]          status;
	logic [63:0]         rest_low;
	logic [63:0]         rest_high;
	logic [LEN_BITS-1:0] rest_len;

	// predictor copy of the word table; entries fill from index zero
	logic [WORD_BITS-1:0]  tbl_word [TABLE_ENTRIES];
	logic [LEN_BITS-1:0]   tbl_len [TABLE_ENTRIES];
	logic [COUNT_BITS-1:0] tbl_count [TABLE_ENTRIES];
	int                    tbl_fill;

	completion_t pending_results[$];
	int          errors;
	int          cycles;
	bit          quiet;
	stim_row_t   dir_rows[18];

	prefix_completion_frequency_table_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .func(func),
		.text_low(text_low), .text_high(text_high), .text_len(text_len),
		.done(done), .status(status), .rest_low(rest_low), .rest_high(rest_high),
		.rest_len(rest_len)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic [WORD_BITS-1:0] clip_word(logic [63:0] lo, logic [63:0] hi,
			int len);
		logic [WORD_BITS-1:0] w;
		w = {hi, lo};
		for (int i = 0; i < MAX_CHARS; i++)
			if (i >= len)
				w[8*i +: 8] = 8'h00;
		return w;
	endfunction

	// negative if a sorts first, a proper prefix sorting before its extensions
	function automatic int word_order(logic [WORD_BITS-1:0] a, int alen,
			logic [WORD_BITS-1:0] b, int blen);
		int n;
		n = (alen < blen) ? alen : blen;
		for (int i = 0; i < n; i++)
			if (a[8*i +: 8] != b[8*i +: 8])
				return (a[8*i +: 8] < b[8*i +: 8]) ? -1 : 1;
		if (alen == blen)
			return 0;
		return (alen < blen) ? -1 : 1;
	endfunction

	task automatic predict_completion(input logic f, input logic [63:0] lo,
			input logic [63:0] hi, input logic [LEN_BITS-1:0] raw_len,
			output completion_t r);
		int                   len;
		int                   best;
		logic [WORD_BITS-1:0] w;
		logic [WORD_BITS-1:0] tail;
		logic [WORD_BITS-1:0] mask;
		len = (raw_len > MAX_CHARS) ? MAX_CHARS : raw_len;
		w = clip_word(lo, hi, len);
		r = '{ST_NOMATCH, 64'h0, 64'h0, '0};
		best = -1;
		if (f == FUNC_UPDATE) begin
			for (int i = 0; i < tbl_fill; i++)
				if (tbl_len[i] == len && tbl_word[i] == w)
					best = i;
			if (best >= 0) begin
				if (tbl_count[best] != COUNT_MAX)
					tbl_count[best]++;
				r.status = ST_AGAIN;
			end else if (tbl_fill == TABLE_ENTRIES) begin
				r.status = ST_FULL;
			end else begin
				tbl_word[tbl_fill] = w;
				tbl_len[tbl_fill] = LEN_BITS'(len);
				tbl_count[tbl_fill] = 1;
				tbl_fill++;
				r.status = ST_ADDED;
			end
		end else begin
			mask = clip_word('1, '1, len);
			for (int i = 0; i < tbl_fill; i++) begin
				if (tbl_len[i] < len || ((tbl_word[i] ^ w) & mask) != '0)
					continue;
				if (best < 0 || tbl_count[i] > tbl_count[best] ||
						(tbl_count[i] == tbl_count[best] &&
						word_order(tbl_word[i], tbl_len[i], tbl_word[best],
						tbl_len[best]) < 0))
					best = i;
			end
			if (best >= 0) begin
				tail = tbl_word[best] >> (8 * len);
				r = '{ST_FOUND, tail[63:0], tail[127:64],
					LEN_BITS'(tbl_len[best] - len)};
			end
		end
	endtask

	// sometimes fill the bytes past the length with junk, and sometimes overstate a full length
	function automatic void add_junk(inout logic [63:0] lo, inout logic [63:0] hi,
			inout logic [LEN_BITS-1:0] len);
		logic [WORD_BITS-1:0] w;
		w = {hi, lo};
		if ($urandom_range(0, 1))
			for (int i = len; i < MAX_CHARS; i++)
				w[8*i +: 8] = 8'($urandom_range(0, 255));
		if (len == MAX_CHARS && $urandom_range(0, 2) == 0)
			len = LEN_BITS'($urandom_range(MAX_CHARS + 1, 31));
		{hi, lo} = w;
	endfunction

	function automatic void random_word(output logic [63:0] lo, output logic [63:0] hi,
			output logic [LEN_BITS-1:0] len);
		logic [WORD_BITS-1:0] w;
		w = '0;
		len = LEN_BITS'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 16)
			: $urandom_range(1, 5));
		for (int i = 0; i < len; i++)
			w[8*i +: 8] = 8'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
				: 32'h61 + $urandom_range(0, 3));
		{hi, lo} = w;
	endfunction

	task automatic gen_item(input bit fill_only, output logic f, output logic [63:0] lo,
			output logic [63:0] hi, output logic [LEN_BITS-1:0] len);
		int r;
		int k;
		r = fill_only ? 0 : $urandom_range(0, 99);
		if (r >= 45 && r < 90 && tbl_fill > 0) begin
			k = $urandom_range(0, tbl_fill - 1);
			{hi, lo} = tbl_word[k];
			len = tbl_len[k];
			if (r < 65) begin
				f = FUNC_UPDATE;
			end else begin
				f = FUNC_SEARCH;
				len = LEN_BITS'($urandom_range(0, tbl_len[k]));
				{hi, lo} = clip_word(lo, hi, len);
			end
		end else begin
			random_word(lo, hi, len);
			f = (r < 90) ? FUNC_UPDATE : FUNC_SEARCH;
		end
		add_junk(lo, hi, len);
	endtask

	task automatic send(input stim_row_t row);
		completion_t r;
		func <= row.f;
		text_low <= row.lo;
		text_high <= row.hi;
		text_len <= row.len;
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predict_completion(row.f, row.lo, row.hi, row.len, r);
		if (row.typed)
			r = '{row.st, 64'h0, 64'h0, '0};
		pending_results.push_back(r);
		if (!quiet && $urandom_range(0, 99) < 32) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8))
				@(posedge clk);
		end
	endtask

	always @(posedge clk) begin
		completion_t e;
		if (done) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected transaction, status %0d", $time, status);
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (status !== e.status) begin
					$display("%0t: status exp %0d got %0d", $time, e.status, status);
					errors++;
				end
				if (rest_low !== e.rest_low) begin
					$display("%0t: rest_low exp %h got %h", $time, e.rest_low, rest_low);
					errors++;
				end
				if (rest_high !== e.rest_high) begin
					$display("%0t: rest_high exp %h got %h", $time, e.rest_high, rest_high);
					errors++;
				end
				if (rest_len !== e.rest_len) begin
					$display("%0t: rest_len exp %0d got %0d", $time, e.rest_len, rest_len);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		stim_row_t row;
		errors = 0;
		cycles = 0;
		tbl_fill = 0;
		quiet = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		func = FUNC_UPDATE;
		text_low = '0;
		text_high = '0;
		text_len = '0;

		// typed rows carry no suffix; the rest go through the predictor
		dir_rows[0]  = '{FUNC_SEARCH, 64'h0, 64'h0, 5'd0, 1'b1, ST_NOMATCH};
		dir_rows[1]  = '{FUNC_UPDATE, 64'h0, 64'h0, 5'd0, 1'b1, ST_ADDED};
		dir_rows[2]  = '{FUNC_UPDATE, 64'hFFFF, 64'h0, 5'd0, 1'b1, ST_AGAIN};
		dir_rows[3]  = '{FUNC_SEARCH, 64'h0, 64'h0, 5'd0, 1'b1, ST_FOUND};
		dir_rows[4]  = '{FUNC_UPDATE, '1, '1, 5'd16, 1'b1, ST_ADDED};
		dir_rows[5]  = '{FUNC_UPDATE, '1, '1, 5'd31, 1'b1, ST_AGAIN};
		dir_rows[6]  = '{FUNC_UPDATE, 64'h1234_5678_9ABC_6261, '1, 5'd2, 1'b1, ST_ADDED};
		dir_rows[7]  = '{FUNC_UPDATE, 64'h620061, 64'h0, 5'd3, 1'b1, ST_ADDED};
		dir_rows[8]  = '{FUNC_SEARCH, 64'h61, 64'h0, 5'd1, 1'b0, ST_FOUND};
		dir_rows[9]  = '{FUNC_SEARCH, '1, '1, 5'd16, 1'b1, ST_FOUND};
		dir_rows[10] = '{FUNC_SEARCH, '1, '1, 5'd0, 1'b0, ST_FOUND};
		dir_rows[11] = '{FUNC_SEARCH, 64'h7A, 64'h0, 5'd1, 1'b1, ST_NOMATCH};
		dir_rows[12] = '{FUNC_SEARCH, 64'hFF, 64'h0, 5'd1, 1'b0, ST_FOUND};
		dir_rows[13] = '{FUNC_UPDATE, 64'h6261, 64'h0, 5'd2, 1'b1, ST_AGAIN};
		dir_rows[14] = '{FUNC_SEARCH, 64'hAA61, 64'h0, 5'd1, 1'b0, ST_FOUND};
		dir_rows[15] = '{FUNC_UPDATE, 64'h0, 64'h0, 5'd16, 1'b1, ST_ADDED};
		dir_rows[16] = '{FUNC_SEARCH, 64'h0, '1, 5'd8, 1'b0, ST_FOUND};
		dir_rows[17] = '{FUNC_SEARCH, '1, '1, 5'd20, 1'b1, ST_FOUND};

		repeat (8)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send(dir_rows[i]);

		row.typed = 1'b0;
		row.st = ST_FOUND;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			quiet = (n >= 40 && n < 100);
			gen_item(1'b0, row.f, row.lo, row.hi, row.len);
			send(row);
		end
		quiet = 1'b0;
		// push the table to full, then exercise it there
		while (tbl_fill < TABLE_ENTRIES) begin
			gen_item(1'b1, row.f, row.lo, row.hi, row.len);
			send(row);
		end
		for (int n = 0; n < 30; n++) begin
			gen_item(1'b0, row.f, row.lo, row.hi, row.len);
			send(row);
		end
		start <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (errors == 0 && pending_results.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
